@@ rtl/dva_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum voice allocator package
// Shared constants, codes and payload types of the voice allocator.
// ----------------------------------------------------------------------------
package dva_pkg;

   localparam int VOICES = 16;
   localparam int VIDX_W = $clog2(VOICES);
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int AGE_W  = 16;
   localparam int THR_W  = 7;

   localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;
   localparam logic [THR_W-1:0] THR_RESET = 7'd2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_TRIGGER = 2'd1,
      OP_DONE    = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_TICK,
      SEQ_SCAN,
      SEQ_WRITE
   } seq_state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_AGE,
      WR_CLAIM,
      WR_FREE
   } wr_kind_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] pad;
      logic [7:0] loudness;
      logic [3:0] finished_voice;
   } req_type;

   typedef struct packed {
      logic [3:0] voice_index;
      logic       stolen;
   } rsp_type;

   typedef struct packed {
      wr_kind_type       kind;
      logic [VIDX_W-1:0] idx;
      logic [AGE_W-1:0]  age;
      logic [7:0]        pad;
      logic [7:0]        loud;
   } voice_wr_type;

   typedef struct packed {
      logic             active;
      logic [AGE_W-1:0] age;
      logic [7:0]       pad;
      logic [7:0]       loud;
   } voice_rd_type;

endpackage
`default_nettype wire

@@ rtl/dva_voice_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voice bank
// Per-voice playing flag, age, pad and loudness with one read and one write.
// ----------------------------------------------------------------------------
module dva_voice_bank (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dva_pkg::voice_wr_type       wr,
   input  wire logic [dva_pkg::VIDX_W-1:0]  rd_idx,
   output dva_pkg::voice_rd_type            rd
);
   import dva_pkg::*;

   logic             active_ff [VOICES];
   logic [AGE_W-1:0] age_ff    [VOICES];
   logic [7:0]       pad_ff    [VOICES];
   logic [7:0]       loud_ff   [VOICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         case (wr.kind)
            WR_CLAIM: active_ff[wr.idx] <= 1'b1;
            WR_FREE:  active_ff[wr.idx] <= 1'b0;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (wr.kind)
         WR_AGE, WR_FREE: begin
            age_ff[wr.idx] <= wr.age;
         end
         WR_CLAIM: begin
            age_ff[wr.idx]  <= wr.age;
            pad_ff[wr.idx]  <= wr.pad;
            loud_ff[wr.idx] <= wr.loud;
         end
         default: ;
      endcase
   end

   always_comb begin
      rd.active = active_ff[rd_idx];
      rd.age    = age_ff[rd_idx];
      rd.pad    = pad_ff[rd_idx];
      rd.loud   = loud_ff[rd_idx];
   end

endmodule
`default_nettype wire

@@ rtl/dva_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation sequencer
// Walks the voice bank one voice per cycle for ticks and triggers.
// ----------------------------------------------------------------------------
module dva_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire dva_pkg::req_type            req_payload,
   input  wire logic [dva_pkg::THR_W-1:0]   thr,
   input  wire logic                        slot_free,
   output dva_pkg::voice_wr_type            wr,
   output logic [dva_pkg::VIDX_W-1:0]       rd_idx,
   input  wire dva_pkg::voice_rd_type       rd,
   output logic                             push,
   output dva_pkg::rsp_type                 result
);
   import dva_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [VIDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VIDX_W-1:0] oldest_ff, oldest_in;
   logic [AGE_W-1:0]  oldest_age_ff, oldest_age_in;
   logic [VIDX_W-1:0] bypad_ff, bypad_in;
   logic [AGE_W-1:0]  bypad_age_ff, bypad_age_in;
   logic              have_pad_ff, have_pad_in;
   logic [7:0]        pad_ff, pad_in;
   logic [7:0]        loud_ff, loud_in;
   logic [VIDX_W-1:0] chosen_ff, chosen_in;
   logic              stolen_ff, stolen_in;

   logic              last;
   logic              match;
   logic              fin_ok;
   logic [THR_W-1:0]  need;
   logic [VIDX_W-1:0] pick;

   assign last   = (idx_ff == VIDX_W'(VOICES - 1));
   assign match  = (rd.pad == pad_ff) && (rd.loud < loud_ff);
   assign fin_ok = (32'(req_payload.finished_voice) < 32'(VOICES));
   assign need   = (thr == '0) ? THR_W'(1) : thr;

   always_comb begin
      if (!stolen_ff) begin
         pick = chosen_ff;
      end else if (have_pad_ff && (THR_W'(cnt_ff) >= need)) begin
         pick = bypad_ff;
      end else begin
         pick = oldest_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid && req_payload.op == OP_TICK) begin
               state_in = SEQ_TICK;
            end else if (req_valid && req_payload.op == OP_TRIGGER) begin
               state_in = SEQ_SCAN;
            end
         end
         SEQ_TICK: begin
            if (last) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_SCAN: begin
            if (!rd.active || last) begin
               state_in = SEQ_WRITE;
            end
         end
         SEQ_WRITE: begin
            if (slot_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ready          = (state_ff == SEQ_IDLE);
      rd_idx             = idx_ff;
      push               = 1'b0;
      wr.kind            = WR_NONE;
      wr.idx             = idx_ff;
      wr.age             = '0;
      wr.pad             = pad_ff;
      wr.loud            = loud_ff;
      result.voice_index = 4'(pick);
      result.stolen      = stolen_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid && req_payload.op == OP_DONE && fin_ok) begin
               wr.kind = WR_FREE;
               wr.idx  = VIDX_W'(req_payload.finished_voice);
            end
         end
         SEQ_TICK: begin
            if (rd.active && rd.age != AGE_MAX) begin
               wr.kind = WR_AGE;
               wr.age  = rd.age + AGE_W'(1);
            end
         end
         SEQ_WRITE: begin
            if (slot_free) begin
               wr.kind = WR_CLAIM;
               wr.idx  = pick;
               push    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      oldest_in     = oldest_ff;
      oldest_age_in = oldest_age_ff;
      bypad_in      = bypad_ff;
      bypad_age_in  = bypad_age_ff;
      have_pad_in   = have_pad_ff;
      pad_in        = pad_ff;
      loud_in       = loud_ff;
      chosen_in     = chosen_ff;
      stolen_in     = stolen_ff;
      case (state_ff)
         SEQ_IDLE: begin
            idx_in      = '0;
            cnt_in      = '0;
            have_pad_in = 1'b0;
            pad_in      = req_payload.pad;
            loud_in     = req_payload.loudness;
         end
         SEQ_TICK: begin
            if (!last) begin
               idx_in = idx_ff + VIDX_W'(1);
            end
         end
         SEQ_SCAN: begin
            if (!rd.active) begin
               chosen_in = idx_ff;
               stolen_in = 1'b0;
            end else begin
               if (idx_ff == '0 || rd.age > oldest_age_ff) begin
                  oldest_in     = idx_ff;
                  oldest_age_in = rd.age;
               end
               if (match) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  if (!have_pad_ff || rd.age > bypad_age_ff) begin
                     bypad_in     = idx_ff;
                     bypad_age_in = rd.age;
                     have_pad_in  = 1'b1;
                  end
               end
               if (last) begin
                  stolen_in = 1'b1;
               end else begin
                  idx_in = idx_ff + VIDX_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      oldest_ff     <= oldest_in;
      oldest_age_ff <= oldest_age_in;
      bypad_ff      <= bypad_in;
      bypad_age_ff  <= bypad_age_in;
      have_pad_ff   <= have_pad_in;
      pad_ff        <= pad_in;
      loud_ff       <= loud_in;
      chosen_ff     <= chosen_in;
      stolen_ff     <= stolen_in;
   end

   a_trigger_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.op == OP_TRIGGER) |=> state_ff == SEQ_SCAN)
      else $error("trigger request did not start a scan");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("result pushed into an occupied output slot");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_SCAN |-> 32'(cnt_ff) <= 32'(idx_ff))
      else $error("match count exceeds the number of scanned voices");

   a_claim_once: assert property (@(posedge clock) disable iff (reset)
      push |=> state_ff == SEQ_IDLE && !push)
      else $error("claim did not return the sequencer to idle");

endmodule
`default_nettype wire

@@ rtl/drum_voice_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum voice allocator
// Hands out playback voices to pad triggers, stealing a voice when none is free.
// ----------------------------------------------------------------------------
// A done request frees its voice as it is accepted; a tick walks all voices.
// A trigger scans one voice per cycle until a free voice or the end, then claims
// the voice and registers the result in the same cycle, once the result register is free.
// One request at a time: the input is held while a tick or trigger runs, and a
// trigger holds it longer while the result register is full.
// Reset clears every playing flag and sets the steal threshold to 2.
module drum_voice_allocator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire dva_pkg::req_type           req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output dva_pkg::rsp_type                rsp_payload,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [dva_pkg::THR_W-1:0]  csr_data
);
   import dva_pkg::*;

   logic [THR_W-1:0]  thr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_payload_ff;
   logic              slot_free;
   logic              push;
   rsp_type           result;
   voice_wr_type      wr;
   voice_rd_type      rd;
   logic [VIDX_W-1:0] rd_idx;

   assign csr_ready   = 1'b1;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_payload_ff <= result;
      end
   end

   dva_voice_bank u_bank (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd     (rd)
   );

   dva_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .thr         (thr_ff),
      .slot_free   (slot_free),
      .wr          (wr),
      .rd_idx      (rd_idx),
      .rd          (rd),
      .push        (push),
      .result      (result)
   );

endmodule
`default_nettype wire

@@ bench/drum_voice_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drum voice allocator testbench
// Drives tick, trigger, done and unused-code requests through the request channel, sets
// the steal threshold between phases and checks every voice grant against a
// local prediction of the voice bank, under several back-pressure patterns.
// ----------------------------------------------------------------------------
module drum_voice_allocator_test;
   import dva_pkg::*;

   localparam int CLOCK_HALF       = 5;
   localparam int RESET_CYCLES     = 9;
   localparam int NUM_PHASES       = 6;
   localparam int RANDOM_PER_PHASE = 225;
   localparam int SETTLE_CYCLES    = 2 * VOICES + 8;
   localparam int CYCLE_LIMIT      = 400000;

   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [THR_W-1:0] csr_data    = THR_RESET;

   logic             voice_playing [VOICES];
   logic [AGE_W-1:0] voice_ticks   [VOICES];
   logic [7:0]       voice_pad_of  [VOICES];
   logic [7:0]       voice_level   [VOICES];
   logic [THR_W-1:0] threshold_now = THR_RESET;

   req_type          pending_requests [$];
   rsp_type          expected_grants  [$];
   pace_type         pace = PACE_STEADY;
   int unsigned      failures    = 0;
   int unsigned      cycle_count = 0;

   drum_voice_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic req_type make_request(input op_type op, input logic [7:0] pad,
                                            input logic [7:0] loud, input logic [3:0] fin);
      req_type r;
      r.op             = op;
      r.pad            = pad;
      r.loudness       = loud;
      r.finished_voice = fin;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned sel;
      sel              = $urandom_range(99);
      r.pad            = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
      r.loudness       = 8'($urandom);
      r.finished_voice = 4'($urandom);
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(2))
            0: r.loudness = 8'h00;
            1: r.loudness = 8'h80;
            default: r.loudness = 8'hFF;
         endcase
      end
      if (sel < 50) begin
         r.op = OP_TRIGGER;
      end else if (sel < 75) begin
         r.op = OP_TICK;
      end else if (sel < 93) begin
         r.op = OP_DONE;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // Advances the voice bank by one accepted request and queues the grant of a trigger.
   task automatic apply_request(input req_type r);
      int      v;
      int      chosen;
      int      oldest;
      int      by_pad;
      int      match_count;
      int      need;
      bit      have_pad;
      rsp_type grant;
      chosen      = -1;
      oldest      = 0;
      by_pad      = 0;
      match_count = 0;
      have_pad    = 1'b0;
      case (r.op)
         OP_TICK: begin
            for (v = 0; v < VOICES; v++) begin
               if (voice_playing[v] && voice_ticks[v] != AGE_MAX) begin
                  voice_ticks[v] = voice_ticks[v] + 1'b1;
               end
            end
         end
         OP_DONE: begin
            if (int'(r.finished_voice) < VOICES) begin
               voice_playing[r.finished_voice] = 1'b0;
               voice_ticks[r.finished_voice]   = '0;
            end
         end
         OP_TRIGGER: begin
            for (v = 0; v < VOICES; v++) begin
               if (chosen < 0) begin
                  if (!voice_playing[v]) begin
                     chosen = v;
                  end else begin
                     if (voice_ticks[v] > voice_ticks[oldest]) begin
                        oldest = v;
                     end
                     if (voice_pad_of[v] == r.pad && voice_level[v] < r.loudness) begin
                        match_count++;
                        if (!have_pad || voice_ticks[v] > voice_ticks[by_pad]) begin
                           by_pad   = v;
                           have_pad = 1'b1;
                        end
                     end
                  end
               end
            end
            if (chosen >= 0) begin
               grant.stolen = 1'b0;
            end else begin
               grant.stolen = 1'b1;
               need   = (threshold_now == 0) ? 1 : int'(threshold_now);
               chosen = (have_pad && match_count >= need) ? by_pad : oldest;
            end
            voice_playing[chosen] = 1'b1;
            voice_ticks[chosen]   = '0;
            voice_pad_of[chosen]  = r.pad;
            voice_level[chosen]   = r.loudness;
            grant.voice_index     = 4'(chosen);
            expected_grants.push_back(grant);
         end
         default: begin
         end
      endcase
   endtask

   function automatic bit sender_pauses();
      case (pace)
         PACE_SENDER: return $urandom_range(99) < 46;
         PACE_BOTH:   return $urandom_range(99) < 7;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pace)
         PACE_RECEIVER: return $urandom_range(99) < 46;
         PACE_BOTH:     return $urandom_range(99) < 7;
         default:       return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_request(req_payload);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && !sender_pauses()) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin : check_grants
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected response: voice_index %0d, stolen %0d",
                   rsp_payload.voice_index, rsp_payload.stolen);
            failures++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_payload.voice_index !== want.voice_index) begin
               $error("voice_index mismatch: expected %0d, actual %0d",
                      want.voice_index, rsp_payload.voice_index);
               failures++;
            end
            if (rsp_payload.stolen !== want.stolen) begin
               $error("stolen mismatch: expected %0d, actual %0d",
                      want.stolen, rsp_payload.stolen);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("drum_voice_allocator_test failed");
         $finish;
      end
   end

   task automatic write_threshold(input logic [THR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      threshold_now = value;
      csr_valid <= 1'b0;
   endtask

   // Fills all voices with a tie in age, then steals by pad, steals the oldest voice,
   // and finishes the same voice twice before reusing it.
   task automatic queue_directed_requests();
      int i;
      pending_requests.push_back(make_request(OP_TICK, 8'h00, 8'h00, 4'h0));
      pending_requests.push_back(make_request(OP_UNUSED, 8'hFF, 8'hFF, 4'hF));
      pending_requests.push_back(make_request(OP_TRIGGER, 8'h00, 8'h00, 4'h0));
      pending_requests.push_back(make_request(OP_TRIGGER, 8'hFF, 8'hFF, 4'hF));
      for (i = 2; i < VOICES; i++) begin
         if (i == 4) begin
            pending_requests.push_back(make_request(OP_TICK, 8'hFF, 8'hFF, 4'hF));
         end
         pending_requests.push_back(make_request(OP_TRIGGER, 8'h05, 8'(i * 15), 4'(i)));
      end
      pending_requests.push_back(make_request(OP_TRIGGER, 8'h05, 8'hFF, 4'h0));
      pending_requests.push_back(make_request(OP_TRIGGER, 8'hC8, 8'h07, 4'h0));
      pending_requests.push_back(make_request(OP_DONE, 8'h00, 8'h00, 4'hF));
      pending_requests.push_back(make_request(OP_DONE, 8'hFF, 8'hFF, 4'hF));
      pending_requests.push_back(make_request(OP_TRIGGER, 8'h05, 8'h00, 4'h0));
      pending_requests.push_back(make_request(OP_DONE, 8'h00, 8'h00, 4'h0));
   endtask

   initial begin : run_phases
      int      phase;
      int      counted;
      req_type r;
      for (int v = 0; v < VOICES; v++) begin
         voice_playing[v] = 1'b0;
         voice_ticks[v]   = '0;
         voice_pad_of[v]  = 8'hFF;
         voice_level[v]   = 8'h00;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: pace = PACE_STEADY;
            1: begin pace = PACE_SENDER;   write_threshold(7'd1);   end
            2: begin pace = PACE_RECEIVER; write_threshold(7'd64);  end
            3: begin pace = PACE_BOTH;     write_threshold(7'd0);   end
            4: begin pace = PACE_STEADY;   write_threshold(7'd127); end
            default: begin pace = PACE_BOTH; write_threshold(7'd3); end
         endcase
         @(negedge clock);
         if (phase == 0) begin
            queue_directed_requests();
         end
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            r = random_request();
            pending_requests.push_back(r);
            if (r.op != OP_UNUSED) begin
               counted++;
            end
         end
         do begin
            @(negedge clock);
         end while (pending_requests.size() > 0 || req_valid || expected_grants.size() > 0);
         repeat (SETTLE_CYCLES) @(negedge clock);
      end
      if (failures == 0) begin
         $display("drum_voice_allocator_test passed");
      end else begin
         $display("drum_voice_allocator_test failed");
      end
      $finish;
   end

endmodule
